### hdl/d8fd_pkg.sv
// ----------------------------------------------------------------------------
// d8fd_pkg
// Shared constants for the D8 flow direction pipeline: widths, the Q0.16
// diagonal weight and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package d8fd_pkg;

  // default elevation width
  localparam int ELEV_BITS_DEF = 24;

  // eight neighbors, numbered clockwise from north
  localparam int NUM_DIRS = 8;
  localparam int DIR_BITS = 3;

  // 1/sqrt2 in Q0.16 and the extra product bits it adds (sign included)
  localparam int Q16_FRAC_BITS  = 16;
  localparam int WEIGHT_BITS    = 18;
  localparam logic signed [WEIGHT_BITS-1:0] Q16_INV_SQRT2 = 18'sd46341;

  // configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DESCENT_ONLY = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NO_EDGES     = 8'd1;

  // reset values of the registers
  localparam logic DESCENT_ONLY_RST = 1'b1;
  localparam logic NO_EDGES_RST     = 1'b0;

endpackage : d8fd_pkg

`default_nettype wire

### hdl/d8_flow_direction_core.sv
// ----------------------------------------------------------------------------
// d8_flow_direction_core
// D8 steepest-descent direction of one 3x3 elevation window.
// ----------------------------------------------------------------------------
// Throughput: one window per cycle while result_stall is low; five register stages (drop,
//   weight, two tree levels, output) each hold one word and move as a stall allows.
// Reset: rst clears all stage valid bits and sets descent_only=1, no_edges=0.
// Config writes are always taken (cfg_ready is high).
`default_nettype none

module d8_flow_direction_core #(
  parameter int ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration write channel
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [d8fd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic                                 cfg_data,
  // window channel
  input  wire logic                                 item_valid,
  output      logic                                 item_stall,
  input  wire logic signed [ELEV_BITS-1:0]          center_value,
  input  wire logic                                 center_valid,
  input  wire logic signed [ELEV_BITS-1:0]          north_value,
  input  wire logic signed [ELEV_BITS-1:0]          northeast_value,
  input  wire logic signed [ELEV_BITS-1:0]          east_value,
  input  wire logic signed [ELEV_BITS-1:0]          southeast_value,
  input  wire logic signed [ELEV_BITS-1:0]          south_value,
  input  wire logic signed [ELEV_BITS-1:0]          southwest_value,
  input  wire logic signed [ELEV_BITS-1:0]          west_value,
  input  wire logic signed [ELEV_BITS-1:0]          northwest_value,
  input  wire logic [d8fd_pkg::NUM_DIRS-1:0]        neighbor_valid,
  // result channel
  output      logic                                 result_valid,
  input  wire logic                                 result_stall,
  output      logic [d8fd_pkg::DIR_BITS-1:0]        flow_direction,
  output      logic                                 direction_found
);
  import d8fd_pkg::*;

  localparam int DROP_BITS = ELEV_BITS + 1 + WEIGHT_BITS - 1;

  logic                        descent_only;
  logic                        no_edges;
  logic signed [ELEV_BITS-1:0] nbr_value [NUM_DIRS];

  logic                        s1_ready;
  logic                        s1_valid;
  logic signed [ELEV_BITS:0]   s1_dz [NUM_DIRS];
  logic [NUM_DIRS-1:0]         s1_accept;
  logic                        s1_kill;

  logic                        s2_ready;
  logic                        s2_valid;
  logic signed [DROP_BITS-1:0] s2_drop [NUM_DIRS];
  logic [NUM_DIRS-1:0]         s2_accept;
  logic                        s2_kill;

  logic                        s3_ready;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      descent_only <= DESCENT_ONLY_RST;
      no_edges     <= NO_EDGES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DESCENT_ONLY: descent_only <= cfg_data;
        REG_NO_EDGES:     no_edges     <= cfg_data;
        default: ;
      endcase
    end
  end

  // neighbors in direction order
  assign nbr_value[0] = north_value;
  assign nbr_value[1] = northeast_value;
  assign nbr_value[2] = east_value;
  assign nbr_value[3] = southeast_value;
  assign nbr_value[4] = south_value;
  assign nbr_value[5] = southwest_value;
  assign nbr_value[6] = west_value;
  assign nbr_value[7] = northwest_value;

  assign item_stall = !s1_ready;

  d8fd_diff #(
    .ELEV_BITS (ELEV_BITS)
  ) u_diff (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (item_valid),
    .up_ready       (s1_ready),
    .down_ready     (s2_ready),
    .down_valid     (s1_valid),
    .descent_only   (descent_only),
    .no_edges       (no_edges),
    .center_value   (center_value),
    .center_valid   (center_valid),
    .nbr_value      (nbr_value),
    .neighbor_valid (neighbor_valid),
    .dz             (s1_dz),
    .accept         (s1_accept),
    .kill           (s1_kill)
  );

  d8fd_weight #(
    .ELEV_BITS (ELEV_BITS),
    .DROP_BITS (DROP_BITS)
  ) u_weight (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s1_valid),
    .up_ready   (s2_ready),
    .down_ready (s3_ready),
    .down_valid (s2_valid),
    .dz         (s1_dz),
    .accept_in  (s1_accept),
    .kill_in    (s1_kill),
    .drop       (s2_drop),
    .accept     (s2_accept),
    .kill       (s2_kill)
  );

  d8fd_reduce #(
    .DROP_BITS (DROP_BITS)
  ) u_reduce (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (s2_valid),
    .up_ready        (s3_ready),
    .down_ready      (!result_stall),
    .down_valid      (result_valid),
    .drop            (s2_drop),
    .accept          (s2_accept),
    .kill_in         (s2_kill),
    .flow_direction  (flow_direction),
    .direction_found (direction_found)
  );

  // no direction always reads as north
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !direction_found) |-> (flow_direction == '0))
    else $error("flow_direction nonzero with no direction found");

  // input stalls only when a result is waiting at the output
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with an empty output stage");

  // a free output lets the whole pipeline move
  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !item_stall)
    else $error("input stalled while output is free");

  // an accepted window lands in the first stage
  a_enter_stage1: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> s1_valid)
    else $error("accepted window lost at first stage");

endmodule : d8_flow_direction_core

`default_nettype wire

### hdl/d8fd_diff.sv
// ----------------------------------------------------------------------------
// d8fd_diff
// First stage: drop from the center to each neighbor, the per-neighbor
// accept bits and the kill flag for invalid center or missing edges.
// ----------------------------------------------------------------------------
`default_nettype none

module d8fd_diff #(
  parameter int ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  output      logic                        up_ready,
  input  wire logic                        down_ready,
  output      logic                        down_valid,
  input  wire logic                        descent_only,
  input  wire logic                        no_edges,
  input  wire logic signed [ELEV_BITS-1:0] center_value,
  input  wire logic                        center_valid,
  input  wire logic signed [ELEV_BITS-1:0] nbr_value [d8fd_pkg::NUM_DIRS],
  input  wire logic [d8fd_pkg::NUM_DIRS-1:0] neighbor_valid,
  output      logic signed [ELEV_BITS:0]   dz [d8fd_pkg::NUM_DIRS],
  output      logic [d8fd_pkg::NUM_DIRS-1:0] accept,
  output      logic                        kill
);
  import d8fd_pkg::*;

  logic signed [ELEV_BITS:0]   dz_next [NUM_DIRS];
  logic [NUM_DIRS-1:0]         accept_next;

  // exact drop, one bit wider than the elevations
  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      dz_next[i] = $signed({center_value[ELEV_BITS-1], center_value})
                 - $signed({nbr_value[i][ELEV_BITS-1], nbr_value[i]});
      // weights are positive, so the weighted drop is positive iff dz is
      accept_next[i] = neighbor_valid[i]
                     && (!descent_only || (!dz_next[i][ELEV_BITS] && (|dz_next[i])));
    end
  end

  assign up_ready = !down_valid || down_ready;

  // advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  // load word
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dz     <= dz_next;
      accept <= accept_next;
      kill   <= !center_valid || (no_edges && !(&neighbor_valid));
    end
  end

endmodule : d8fd_diff

`default_nettype wire

### hdl/d8fd_weight.sv
// ----------------------------------------------------------------------------
// d8fd_weight
// Second stage: weight each drop in Q.16, a shift for orthogonal
// neighbors and a multiply by 1/sqrt2 for diagonal ones.
// ----------------------------------------------------------------------------
`default_nettype none

module d8fd_weight #(
  parameter int ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF,
  parameter int DROP_BITS = ELEV_BITS + 1 + d8fd_pkg::WEIGHT_BITS - 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  output      logic                        up_ready,
  input  wire logic                        down_ready,
  output      logic                        down_valid,
  input  wire logic signed [ELEV_BITS:0]   dz [d8fd_pkg::NUM_DIRS],
  input  wire logic [d8fd_pkg::NUM_DIRS-1:0] accept_in,
  input  wire logic                        kill_in,
  output      logic signed [DROP_BITS-1:0] drop [d8fd_pkg::NUM_DIRS],
  output      logic [d8fd_pkg::NUM_DIRS-1:0] accept,
  output      logic                        kill
);
  import d8fd_pkg::*;

  localparam int PAD_BITS = DROP_BITS - (ELEV_BITS + 1) - Q16_FRAC_BITS;

  logic signed [DROP_BITS-1:0] drop_next [NUM_DIRS];

  // even index: dz * 1.0, odd index: dz * 1/sqrt2
  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (i % 2 == 0) begin
        drop_next[i] = $signed({{PAD_BITS{dz[i][ELEV_BITS]}}, dz[i],
                                {Q16_FRAC_BITS{1'b0}}});
      end else begin
        drop_next[i] = DROP_BITS'(dz[i] * Q16_INV_SQRT2);
      end
    end
  end

  assign up_ready = !down_valid || down_ready;

  // advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  // load word
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      drop   <= drop_next;
      accept <= accept_in;
      kill   <= kill_in;
    end
  end

endmodule : d8fd_weight

`default_nettype wire

### hdl/d8fd_reduce.sv
// ----------------------------------------------------------------------------
// d8fd_reduce
// Last three stages: registered pairwise tree that picks the largest
// accepted weighted drop, lower index on ties, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module d8fd_reduce #(
  parameter int DROP_BITS = d8fd_pkg::ELEV_BITS_DEF + d8fd_pkg::WEIGHT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          up_valid,
  output      logic                          up_ready,
  input  wire logic                          down_ready,
  output      logic                          down_valid,
  input  wire logic signed [DROP_BITS-1:0]   drop [d8fd_pkg::NUM_DIRS],
  input  wire logic [d8fd_pkg::NUM_DIRS-1:0] accept,
  input  wire logic                          kill_in,
  output      logic [d8fd_pkg::DIR_BITS-1:0] flow_direction,
  output      logic                          direction_found
);
  import d8fd_pkg::*;

  typedef struct packed {
    logic                        found;
    logic [DIR_BITS-1:0]         dir;
    logic signed [DROP_BITS-1:0] drop;
  } cand_t;

  // right side wins only when the left has nothing or it is strictly larger
  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    cand_t res;
    res = lo;
    if (hi.found && (!lo.found || (hi.drop > lo.drop))) begin
      res = hi;
    end
    return res;
  endfunction

  logic [2:0] vld;
  logic [2:0] rdy;
  cand_t      lvl1 [4];
  cand_t      lvl2 [2];
  logic       kill_l1;
  logic       kill_l2;
  cand_t      leaf [NUM_DIRS];
  cand_t      best;

  // leaves of the tree
  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      leaf[i].found = accept[i];
      leaf[i].dir   = DIR_BITS'(i);
      leaf[i].drop  = drop[i];
    end
  end

  assign best = pick(lvl2[0], lvl2[1]);

  // ready chain from the output back
  assign rdy[2]     = !vld[2] || down_ready;
  assign rdy[1]     = !vld[1] || rdy[2];
  assign rdy[0]     = !vld[0] || rdy[1];
  assign up_ready   = rdy[0];
  assign down_valid = vld[2];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= up_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  // tree level one: four pairs
  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      for (int i = 0; i < 4; i++) begin
        lvl1[i] <= pick(leaf[2*i], leaf[2*i+1]);
      end
      kill_l1 <= kill_in;
    end
  end

  // tree level two
  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      lvl2[0] <= pick(lvl1[0], lvl1[1]);
      lvl2[1] <= pick(lvl1[2], lvl1[3]);
      kill_l2 <= kill_l1;
    end
  end

  // final pick into the output register
  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      direction_found <= best.found && !kill_l2;
      flow_direction  <= (best.found && !kill_l2) ? best.dir : '0;
    end
  end

endmodule : d8fd_reduce

`default_nettype wire

### sim/d8fd_direction_checker.sv
// ----------------------------------------------------------------------------
// d8fd_direction_checker
// Watches the configuration, window and result channels of the D8 flow
// direction core. Keeps its own copy of the two mode registers, predicts the
// steepest-descent word for every accepted window and compares each result
// word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

module d8fd_direction_checker #(
  parameter int ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [d8fd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic                                 cfg_data,
  input  logic                                 item_valid,
  input  logic                                 item_stall,
  input  logic signed [ELEV_BITS-1:0]          center_value,
  input  logic                                 center_valid,
  input  logic signed [ELEV_BITS-1:0]          north_value,
  input  logic signed [ELEV_BITS-1:0]          northeast_value,
  input  logic signed [ELEV_BITS-1:0]          east_value,
  input  logic signed [ELEV_BITS-1:0]          southeast_value,
  input  logic signed [ELEV_BITS-1:0]          south_value,
  input  logic signed [ELEV_BITS-1:0]          southwest_value,
  input  logic signed [ELEV_BITS-1:0]          west_value,
  input  logic signed [ELEV_BITS-1:0]          northwest_value,
  input  logic [d8fd_pkg::NUM_DIRS-1:0]        neighbor_valid,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic [d8fd_pkg::DIR_BITS-1:0]        flow_direction,
  input  logic                                 direction_found,
  output int                                   fail_count,
  output int                                   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import d8fd_pkg::*;

  typedef logic signed [ELEV_BITS-1:0] elev_t;
  typedef logic [NUM_DIRS-1:0][ELEV_BITS-1:0] ring_t;

  typedef struct packed {
    logic                found;
    logic [DIR_BITS-1:0] dir;
  } flow_t;

  logic  descent_only_mirror = DESCENT_ONLY_RST;
  logic  no_edges_mirror     = NO_EDGES_RST;
  flow_t expected_flow [$];
  flow_t got;
  flow_t want;
  ring_t neighbor_ring;

  // neighbor 0 (north) sits in the low slice, clockwise upward
  assign neighbor_ring = {northwest_value, west_value, southwest_value, south_value,
                          southeast_value, east_value, northeast_value, north_value};

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Scan neighbors in index order; keep the first accepted one and replace it
  // only on a strictly larger weighted drop.
  function automatic flow_t steepest_flow(elev_t center, logic center_ok, ring_t nbr,
                                          logic [NUM_DIRS-1:0] nbr_ok,
                                          logic descent_mode, logic edge_mode);
    longint drop;
    longint slope;
    longint best;
    logic   blocked;
    flow_t  r;
    r       = '0;
    best    = 0;
    blocked = 1'b0;
    if (center_ok) begin
      for (int i = 0; i < NUM_DIRS; i++) begin
        if (!blocked) begin
          if (nbr_ok[i]) begin
            drop = longint'(center) - longint'(elev_t'(nbr[i]));
            if (i % 2 == 1) begin
              slope = drop * longint'(Q16_INV_SQRT2);
            end else begin
              slope = drop * (longint'(1) << Q16_FRAC_BITS);
            end
            if ((!descent_mode || slope > 0) && (!r.found || slope > best)) begin
              best    = slope;
              r.dir   = i[DIR_BITS-1:0];
              r.found = 1'b1;
            end
          end else if (edge_mode) begin
            blocked = 1'b1;
          end
        end
      end
    end
    if (blocked) begin
      r = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      descent_only_mirror = DESCENT_ONLY_RST;
      no_edges_mirror     = NO_EDGES_RST;
      expected_flow.delete();
    end else begin
      // mirror register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DESCENT_ONLY: descent_only_mirror = cfg_data;
          REG_NO_EDGES:     no_edges_mirror     = cfg_data;
          default: ;
        endcase
      end

      // compare the result word with the oldest prediction
      if (result_valid && !result_stall) begin
        got = {direction_found, flow_direction};
        if (expected_flow.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual found=%0d dir=%0d",
                   $time, got.found, got.dir);
          fail_count++;
        end else begin
          want = expected_flow.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: direction_found expected %0d actual %0d",
                     $time, want.found, got.found);
            fail_count++;
          end
          if (got.dir !== want.dir) begin
            $display("%0t: flow_direction expected %0d actual %0d",
                     $time, want.dir, got.dir);
            fail_count++;
          end
        end
      end

      // predict the word for an accepted window
      if (item_valid && !item_stall) begin
        expected_flow.push_back(steepest_flow(center_value, center_valid, neighbor_ring,
                                              neighbor_valid, descent_only_mirror,
                                              no_edges_mirror));
      end
    end
    pending_count = expected_flow.size();
  end

endmodule : d8fd_direction_checker

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the D8 flow direction core with directed windows (extreme
// elevations, ties, diagonal against orthogonal drops, invalid center and
// neighbors) under every mode setting, then with random windows in bursts
// against a randomly stalling receiver, including one long hold-off that
// backs the pipeline up. The checker predicts and compares every word.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import d8fd_pkg::*;

  localparam int ELEV_BITS         = ELEV_BITS_DEF;
  localparam int LATENCY           = 5;
  localparam int DRAIN_CYCLES      = LATENCY + 4;
  localparam int WATCHDOG_LIMIT    = 5000;
  localparam int HOLD_OFF_CYCLES   = 64;
  localparam int RANDOM_PHASES     = 6;
  localparam int WINDOWS_PER_PHASE = 170;
  localparam int PRESSURE_BURST    = 120;

  // index that maps to no register
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = '1;

  typedef logic signed [ELEV_BITS-1:0] elev_t;

  localparam elev_t ELEV_MAX = {1'b0, {(ELEV_BITS-1){1'b1}}};
  localparam elev_t ELEV_MIN = {1'b1, {(ELEV_BITS-1){1'b0}}};

  typedef struct packed {
    elev_t                              center;
    logic                               center_ok;
    logic [NUM_DIRS-1:0][ELEV_BITS-1:0] nbr;
    logic [NUM_DIRS-1:0]                valid;
  } window_t;

  logic                      clk             = 1'b0;
  logic                      rst             = 1'b1;
  logic                      cfg_valid       = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index       = '0;
  logic                      cfg_data        = 1'b0;
  logic                      item_valid      = 1'b0;
  logic                      item_stall;
  elev_t                     center_value    = '0;
  logic                      center_valid    = 1'b0;
  elev_t                     north_value     = '0;
  elev_t                     northeast_value = '0;
  elev_t                     east_value      = '0;
  elev_t                     southeast_value = '0;
  elev_t                     south_value     = '0;
  elev_t                     southwest_value = '0;
  elev_t                     west_value      = '0;
  elev_t                     northwest_value = '0;
  logic [NUM_DIRS-1:0]       neighbor_valid  = '0;
  logic                      result_valid;
  logic                      result_stall    = 1'b0;
  logic [DIR_BITS-1:0]       flow_direction;
  logic                      direction_found;
  int                        fail_count;
  int                        pending_count;
  int                        idle_cycles     = 0;
  logic                      pressure_go     = 1'b0;

  always #1 clk = ~clk;

  d8_flow_direction_core #(.ELEV_BITS(ELEV_BITS)) u_top (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .item_valid, .item_stall,
    .center_value, .center_valid,
    .north_value, .northeast_value, .east_value, .southeast_value,
    .south_value, .southwest_value, .west_value, .northwest_value,
    .neighbor_valid,
    .result_valid, .result_stall, .flow_direction, .direction_found
  );

  d8fd_direction_checker #(.ELEV_BITS(ELEV_BITS)) u_direction_checker (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .item_valid, .item_stall,
    .center_value, .center_valid,
    .north_value, .northeast_value, .east_value, .southeast_value,
    .south_value, .southwest_value, .west_value, .northwest_value,
    .neighbor_valid,
    .result_valid, .result_stall, .flow_direction, .direction_found,
    .fail_count, .pending_count
  );

  // Abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: stall in segments of random density; once pressure starts,
  // hold off for a long stretch so the pipeline fills and stalls its input
  initial begin
    int  mode;
    int  seg;
    logic held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 60);
      repeat (seg) begin
        if (pressure_go && !held) begin
          result_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 1) == 0);
          default: result_stall <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic window_t flat_window(elev_t c, elev_t n, logic [NUM_DIRS-1:0] v);
    window_t w;
    w.center    = c;
    w.center_ok = 1'b1;
    for (int i = 0; i < NUM_DIRS; i++) begin
      w.nbr[i] = n;
    end
    w.valid = v;
    return w;
  endfunction

  // Mostly neighbors close to the center (ties, diagonal vs orthogonal),
  // plus full-range values and the extremes
  function automatic window_t random_window();
    window_t     w;
    int          pick;
    int          lift;
    logic [31:0] r;
    pick = $urandom_range(0, 7);
    r    = $urandom;
    w.center    = (pick == 0) ? ELEV_MIN : (pick == 1) ? ELEV_MAX : elev_t'(r);
    w.center_ok = ($urandom_range(0, 7) != 0);
    r           = $urandom;
    w.valid     = ($urandom_range(0, 1) == 0) ? '1 : r[NUM_DIRS-1:0];
    for (int i = 0; i < NUM_DIRS; i++) begin
      pick = $urandom_range(0, 9);
      r    = $urandom;
      case (pick)
        0, 1, 2, 3, 4, 5: begin
          lift     = int'($urandom_range(0, 600)) - 300 + int'(w.center);
          w.nbr[i] = lift[ELEV_BITS-1:0];
        end
        6:       w.nbr[i] = r[ELEV_BITS-1:0];
        7:       w.nbr[i] = ELEV_MIN;
        8:       w.nbr[i] = ELEV_MAX;
        default: w.nbr[i] = w.center;
      endcase
    end
    return w;
  endfunction

  // Present one window and hold it until accepted
  task automatic send_window(window_t w);
    item_valid      <= 1'b1;
    center_value    <= w.center;
    center_valid    <= w.center_ok;
    north_value     <= w.nbr[0];
    northeast_value <= w.nbr[1];
    east_value      <= w.nbr[2];
    southeast_value <= w.nbr[3];
    south_value     <= w.nbr[4];
    southwest_value <= w.nbr[5];
    west_value      <= w.nbr[6];
    northwest_value <= w.nbr[7];
    neighbor_valid  <= w.valid;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word is out
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_mode(logic descent, logic edges, logic poke_unused);
    wait_idle();
    write_reg(REG_DESCENT_ONLY, descent);
    write_reg(REG_NO_EDGES, edges);
    if (poke_unused) begin
      write_reg(REG_UNUSED, ~descent);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    window_t w;
    int      burst_left;
    int      gap;
    logic    descent;
    logic    edges;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset modes: descent only, edges skipped
    send_window(flat_window(ELEV_MAX, ELEV_MIN, '1));
    send_window(flat_window(ELEV_MIN, ELEV_MAX, '1));
    send_window(flat_window('0, '0, '1));
    w = flat_window(ELEV_MAX, ELEV_MIN, '1);
    w.center_ok = 1'b0;
    send_window(w);
    send_window(flat_window(ELEV_MAX, ELEV_MIN, '0));
    // equal diagonal drops: lowest diagonal index wins
    send_window(flat_window(elev_t'(100), '0, 8'hAA));
    // diagonal just beats, then just loses to, the north drop
    w = flat_window('0, '0, '1);
    w.nbr[0] = elev_t'(-100);
    w.nbr[1] = elev_t'(-142);
    send_window(w);
    w.nbr[1] = elev_t'(-141);
    send_window(w);
    w = flat_window(elev_t'(5), elev_t'(10), '1);
    w.nbr[6] = elev_t'(4);
    send_window(w);
    w = flat_window('0, '0, '1);
    w.nbr[7] = elev_t'(-1);
    send_window(w);

    // any slope accepted, edges skipped
    set_mode(1'b0, 1'b0, 1'b0);
    send_window(flat_window(ELEV_MIN, ELEV_MAX, '1));
    send_window(flat_window('0, '0, '1));
    send_window(flat_window('0, elev_t'(5), 8'h80));
    w = flat_window('0, '0, '1);
    w.center_ok = 1'b0;
    send_window(w);
    w = flat_window('0, elev_t'(10), '1);
    w.nbr[3] = elev_t'(9);
    send_window(w);

    // any slope accepted, a missing neighbor blocks the window
    set_mode(1'b0, 1'b1, 1'b1);
    send_window(flat_window('0, elev_t'(5), '1));
    send_window(flat_window('0, elev_t'(5), 8'h7F));
    send_window(flat_window('0, elev_t'(5), '0));
    send_window(flat_window(ELEV_MAX, ELEV_MIN, 8'hFE));

    // descent only, a missing neighbor blocks the window
    set_mode(1'b1, 1'b1, 1'b0);
    send_window(flat_window(ELEV_MAX, ELEV_MIN, '1));
    send_window(flat_window(ELEV_MAX, ELEV_MIN, 8'hFE));
    w = flat_window('0, '0, '1);
    w.nbr[5] = elev_t'(-3);
    send_window(w);

    // random windows in bursts; the first phase starts with one long gapless burst
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin descent = 1'b1; edges = 1'b0; end
        1: begin descent = 1'b0; edges = 1'b0; end
        2: begin descent = 1'b0; edges = 1'b1; end
        3: begin descent = 1'b1; edges = 1'b1; end
        default: begin
          descent = 1'($urandom_range(0, 1));
          edges   = 1'($urandom_range(0, 1));
        end
      endcase
      set_mode(descent, edges, p == RANDOM_PHASES - 1);
      burst_left = 0;
      if (p == 0) begin
        pressure_go = 1'b1;
        burst_left  = PRESSURE_BURST;
      end
      for (int n = 0; n < WINDOWS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = $urandom_range(1, 40);
          if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_window(random_window());
        burst_left--;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule : testbench

### files.f
hdl/d8fd_pkg.sv
hdl/d8fd_diff.sv
hdl/d8fd_weight.sv
hdl/d8fd_reduce.sv
hdl/d8_flow_direction_core.sv
sim/d8fd_direction_checker.sv
sim/testbench.sv
